>>> hdl/rgs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rgs_pkg;

    // fixed field widths of the transactions
    localparam int SYM_W       = 8;
    localparam int LEN_OUT_W   = 17;
    localparam int START_OUT_W = 16;

    typedef struct packed {
        logic [SYM_W-1:0] symbol_in;
        logic             end_of_string;
    } t_rgs_in;

    typedef struct packed {
        logic [LEN_OUT_W-1:0]   run_length;
        logic [SYM_W-1:0]       run_symbol;
        logic [START_OUT_W-1:0] run_start;
        logic                   overflow;
        logic                   last_run;
    } t_rgs_out;

    // chain control broadcast to every cell
    typedef struct packed {
        logic ins;   // insert the broadcast run in order
        logic shl;   // shift toward cell 0 (drain)
    } t_chain_ctl;

endpackage

`default_nettype wire

>>> hdl/run_grouping_sort_by_length_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// run grouping with ordering by run length
// input channel: one byte per transaction, end_of_string marks the last byte of a string.
// consecutive equal bytes form a run; each closed run is inserted into a chain of
// MAX_RUNS cells kept sorted by length (longest first, equal lengths by earlier start).
// throughput: one byte per cycle while a string streams in; the insert is a single
// broadcast to the chain, every cell decides keep / take new / take left neighbor.
// after the end-marked byte the input stalls: the flush step closes the final run, then
// the runs leave from cell 0, one result transaction per cycle while the receiver does
// not stall, the chain shifting toward cell 0 on each accepted result. the next byte is
// taken once the last run of the string has been accepted.
// while the receiver stalls, the result payload (cell 0) holds and nothing moves.
// runs closed while the chain is full and bytes at index MAX_INPUT or beyond are
// dropped; overflow is then set on every result of that string.
// reset clears the run tracker, fill count and sequencer; cell contents need none,
// only the first run count cells are ever read.

module run_grouping_sort_by_length_unit
    import rgs_pkg::*;
#(
    parameter int MAX_RUNS  = 64,
    parameter int MAX_INPUT = 65536
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    output logic       o_in_stall,
    input  wire t_rgs_in i_in_data,
    output logic       o_out_valid,
    input  wire        i_out_stall,
    output t_rgs_out   o_out_data
);

    localparam int COUNT_W = $clog2(MAX_RUNS + 1);
    localparam int POS_W   = $clog2(MAX_INPUT + 1);
    localparam int LEN_W   = POS_W;
    localparam int START_W = $clog2(MAX_INPUT);

    localparam logic [POS_W-1:0]   POS_LIMIT  = POS_W'(MAX_INPUT);
    localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(MAX_RUNS);

    // sequencer states
    localparam logic [1:0] S_RUN   = 2'd0;   // taking bytes
    localparam logic [1:0] S_FLUSH = 2'd1;   // close the final run
    localparam logic [1:0] S_DRAIN = 2'd2;   // emit runs from cell 0

    logic [1:0]         r_state, n_state;
    logic [SYM_W-1:0]   r_cur_sym, n_cur_sym;
    logic [LEN_W-1:0]   r_cur_len, n_cur_len;
    logic [START_W-1:0] r_cur_start, n_cur_start;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [COUNT_W-1:0] r_count, n_count;
    logic               r_ovf, n_ovf;

    logic       in_accept;
    logic       out_accept;
    logic       in_range;
    logic       ins_req;
    logic       chain_full;
    t_chain_ctl chain_ctl;

    // per-cell taps of the chain
    logic [LEN_W-1:0]   c_len   [MAX_RUNS];
    logic [SYM_W-1:0]   c_sym   [MAX_RUNS];
    logic [START_W-1:0] c_start [MAX_RUNS];
    logic               c_keep  [MAX_RUNS];

    assign o_in_stall = (r_state != S_RUN);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_state == S_DRAIN) && (r_count != '0);
    assign out_accept  = o_out_valid && !i_out_stall;

    assign in_range   = (r_pos < POS_LIMIT);
    assign chain_full = (r_count == COUNT_FULL);

    // a run closes when a different byte arrives, or at the flush step
    always_comb begin
        ins_req = 1'b0;
        if (r_state == S_RUN) begin
            ins_req = in_accept && in_range && (r_cur_len != '0)
                      && (i_in_data.symbol_in != r_cur_sym);
        end else if (r_state == S_FLUSH) begin
            ins_req = (r_cur_len != '0);
        end
    end

    assign chain_ctl.ins = ins_req && !chain_full;
    assign chain_ctl.shl = out_accept;

    always_comb begin
        n_state     = r_state;
        n_cur_sym   = r_cur_sym;
        n_cur_len   = r_cur_len;
        n_cur_start = r_cur_start;
        n_pos       = r_pos;
        n_count     = r_count;
        n_ovf       = r_ovf;

        // a dropped run marks the string
        if (ins_req && chain_full) begin
            n_ovf = 1'b1;
        end
        if (chain_ctl.ins) begin
            n_count = r_count + COUNT_W'(1);
        end else if (chain_ctl.shl) begin
            n_count = r_count - COUNT_W'(1);
        end

        unique case (r_state)
            S_RUN: begin
                if (in_accept) begin
                    if (!in_range) begin
                        n_ovf = 1'b1;
                    end else begin
                        if ((r_cur_len != '0) && (i_in_data.symbol_in == r_cur_sym)) begin
                            n_cur_len = r_cur_len + LEN_W'(1);
                        end else begin
                            // open a new run at this byte
                            n_cur_sym   = i_in_data.symbol_in;
                            n_cur_len   = LEN_W'(1);
                            n_cur_start = r_pos[START_W-1:0];
                        end
                        n_pos = r_pos + POS_W'(1);
                    end
                    if (i_in_data.end_of_string) begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                n_cur_sym   = '0;
                n_cur_len   = '0;
                n_cur_start = '0;
                n_pos       = '0;
                n_state     = S_DRAIN;
            end
            S_DRAIN: begin
                if ((r_count == '0) || (out_accept && (r_count == COUNT_W'(1)))) begin
                    n_ovf   = 1'b0;
                    n_state = S_RUN;
                end
            end
            default: begin
                n_state = S_RUN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RUN;
            r_cur_sym   <= '0;
            r_cur_len   <= '0;
            r_cur_start <= '0;
            r_pos       <= '0;
            r_count     <= '0;
            r_ovf       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur_sym   <= n_cur_sym;
            r_cur_len   <= n_cur_len;
            r_cur_start <= n_cur_start;
            r_pos       <= n_pos;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
        end
    end

    // sorted chain of run cells, cell 0 holds the longest run
    for (genvar gi = 0; gi < MAX_RUNS; gi++) begin : g_cell
        logic               occ;
        logic               prev_keep;
        logic [LEN_W-1:0]   prev_len;
        logic [SYM_W-1:0]   prev_sym;
        logic [START_W-1:0] prev_start;
        logic [LEN_W-1:0]   next_len;
        logic [SYM_W-1:0]   next_sym;
        logic [START_W-1:0] next_start;

        assign occ = (COUNT_W'(gi) < r_count);

        if (gi == 0) begin : g_head
            assign prev_keep  = 1'b1;
            assign prev_len   = '0;
            assign prev_sym   = '0;
            assign prev_start = '0;
        end else begin : g_body
            assign prev_keep  = c_keep[gi-1];
            assign prev_len   = c_len[gi-1];
            assign prev_sym   = c_sym[gi-1];
            assign prev_start = c_start[gi-1];
        end

        if (gi == MAX_RUNS - 1) begin : g_tail
            assign next_len   = '0;
            assign next_sym   = '0;
            assign next_start = '0;
        end else begin : g_link
            assign next_len   = c_len[gi+1];
            assign next_sym   = c_sym[gi+1];
            assign next_start = c_start[gi+1];
        end

        rgs_cell #(
            .LEN_W   (LEN_W),
            .START_W (START_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (chain_ctl),
            .i_occ        (occ),
            .i_prev_keep  (prev_keep),
            .i_new_len    (r_cur_len),
            .i_new_sym    (r_cur_sym),
            .i_new_start  (r_cur_start),
            .i_prev_len   (prev_len),
            .i_prev_sym   (prev_sym),
            .i_prev_start (prev_start),
            .i_next_len   (next_len),
            .i_next_sym   (next_sym),
            .i_next_start (next_start),
            .o_keep       (c_keep[gi]),
            .o_len        (c_len[gi]),
            .o_sym        (c_sym[gi]),
            .o_start      (c_start[gi])
        );
    end

    // result transaction straight from cell 0
    always_comb begin
        o_out_data.run_length = LEN_OUT_W'(c_len[0]);
        o_out_data.run_symbol = c_sym[0];
        o_out_data.run_start  = START_OUT_W'(c_start[0]);
        o_out_data.overflow   = r_ovf;
        o_out_data.last_run   = (r_count == COUNT_W'(1));
    end

    // fill count never passes the chain length
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_FULL)
        else $error("run count exceeds chain length");

    // a full chain never takes another run
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        chain_ctl.ins |-> (r_count < COUNT_FULL))
        else $error("insert into full chain");

    // bytes are never taken while results are pending
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input open during drain");

    // the final run of a string ends the result burst
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_accept && o_out_data.last_run) |=> (!o_out_valid && !o_in_stall))
        else $error("results continue after last run");

    // chain head stays ordered by length
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= COUNT_W'(2)) |-> (c_len[0] >= c_len[1]))
        else $error("chain out of order");

endmodule

`default_nettype wire

>>> hdl/rgs_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module rgs_cell
    import rgs_pkg::*;
#(
    parameter int LEN_W   = 17,
    parameter int START_W = 16
) (
    input  wire                    i_clk,
    input  wire t_chain_ctl        i_ctl,
    input  wire                    i_occ,
    input  wire                    i_prev_keep,
    input  wire [LEN_W-1:0]        i_new_len,
    input  wire [SYM_W-1:0]        i_new_sym,
    input  wire [START_W-1:0]      i_new_start,
    input  wire [LEN_W-1:0]        i_prev_len,
    input  wire [SYM_W-1:0]        i_prev_sym,
    input  wire [START_W-1:0]      i_prev_start,
    input  wire [LEN_W-1:0]        i_next_len,
    input  wire [SYM_W-1:0]        i_next_sym,
    input  wire [START_W-1:0]      i_next_start,
    output logic                   o_keep,
    output logic [LEN_W-1:0]       o_len,
    output logic [SYM_W-1:0]       o_sym,
    output logic [START_W-1:0]     o_start
);

    logic [LEN_W-1:0]   r_len,   n_len;
    logic [SYM_W-1:0]   r_sym,   n_sym;
    logic [START_W-1:0] r_start, n_start;

    // an occupied entry at least as long as the new run stays put (ties keep older first)
    assign o_keep = i_occ && (r_len >= i_new_len);

    always_comb begin
        n_len   = r_len;
        n_sym   = r_sym;
        n_start = r_start;
        if (i_ctl.shl) begin
            n_len   = i_next_len;
            n_sym   = i_next_sym;
            n_start = i_next_start;
        end else if (i_ctl.ins && !o_keep) begin
            if (i_prev_keep) begin
                n_len   = i_new_len;
                n_sym   = i_new_sym;
                n_start = i_new_start;
            end else begin
                n_len   = i_prev_len;
                n_sym   = i_prev_sym;
                n_start = i_prev_start;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_len   <= n_len;
        r_sym   <= n_sym;
        r_start <= n_start;
    end

    assign o_len   = r_len;
    assign o_sym   = r_sym;
    assign o_start = r_start;

endmodule

`default_nettype wire

>>> tb/tb_run_grouping_sort_by_length_unit.sv
`timescale 1ns / 1ps

module tb_run_grouping_sort_by_length_unit;
    import rgs_pkg::*;

    // block configuration, kept at the design defaults
    localparam int MAX_RUNS  = 64;
    localparam int MAX_INPUT = 65536;

    // idling percentage on each side, receiver hold-off length, drain allowance
    localparam int IDLE_PCT    = 20;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = MAX_RUNS + 16;
    localparam int RANDOM_BYTES = 24;

    // one stored run as the predictor keeps it
    typedef struct packed {
        logic [LEN_OUT_W-1:0]   len;
        logic [SYM_W-1:0]       sym;
        logic [START_OUT_W-1:0] start;
    } t_held_run;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     in_valid = 1'b0;
    t_rgs_in  in_data = '0;
    logic     out_stall = 1'b0;
    logic     o_in_stall;
    logic     o_out_valid;
    t_rgs_out o_out_data;

    // bytes waiting to be driven, filled by the stimulus process
    t_rgs_in  bytes_to_send[$];
    // run transactions expected on the output, oldest first
    t_rgs_out runs_due[$];

    // predictor state for the string in progress
    t_held_run              sorted_runs[MAX_RUNS];
    logic [SYM_W-1:0]       open_sym = '0;
    logic [LEN_OUT_W-1:0]   open_len = '0;
    logic [START_OUT_W-1:0] open_start = '0;
    logic [LEN_OUT_W-1:0]   byte_pos = '0;
    int                     runs_held = 0;
    logic                   lost_flag = 1'b0;

    // bookkeeping
    int   bytes_queued = 0;
    int   bytes_taken = 0;
    int   strings_queued = 0;
    int   runs_checked = 0;
    int   overflow_runs = 0;
    int   mismatches = 0;
    int   unexpected = 0;
    logic steady = 1'b0;     // no idling on either side while set
    logic hold_go = 1'b0;    // arms the one long receiver hold-off
    int   hold_count = 0;

    run_grouping_sort_by_length_unit #(
        .MAX_RUNS  (MAX_RUNS),
        .MAX_INPUT (MAX_INPUT)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // insert the open run behind every held run that is not shorter
    function automatic void close_open_run();
        int slot;
        if (open_len == '0) return;
        if (runs_held >= MAX_RUNS) begin
            // table full: the run is lost, earlier runs stay
            lost_flag = 1'b1;
            return;
        end
        slot = runs_held;
        while (slot > 0 && sorted_runs[slot-1].len < open_len) begin
            sorted_runs[slot] = sorted_runs[slot-1];
            slot--;
        end
        sorted_runs[slot] = '{len: open_len, sym: open_sym, start: open_start};
        runs_held++;
    endfunction

    // advance the run tracker by one accepted byte, queue the runs on an end mark
    function automatic void predict_byte(t_rgs_in b);
        t_rgs_out res;
        if (byte_pos >= MAX_INPUT) begin
            // past the position range: byte dropped, string still ends on its mark
            lost_flag = 1'b1;
        end else begin
            if (open_len == '0) begin
                open_sym   = b.symbol_in;
                open_len   = 1;
                open_start = byte_pos[START_OUT_W-1:0];
            end else if (b.symbol_in == open_sym) begin
                open_len++;
            end else begin
                close_open_run();
                open_sym   = b.symbol_in;
                open_len   = 1;
                open_start = byte_pos[START_OUT_W-1:0];
            end
            byte_pos++;
        end
        if (!b.end_of_string) return;
        close_open_run();
        for (int k = 0; k < runs_held; k++) begin
            res.run_length = sorted_runs[k].len;
            res.run_symbol = sorted_runs[k].sym;
            res.run_start  = sorted_runs[k].start;
            res.overflow   = lost_flag;
            res.last_run   = (k == runs_held - 1);
            runs_due.push_back(res);
        end
        // per-string state back to its cleared values, table left as is
        open_sym   = '0;
        open_len   = '0;
        open_start = '0;
        byte_pos   = '0;
        runs_held  = 0;
        lost_flag  = 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // input driver: pops the next byte once the previous transaction is taken
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end else begin
            if (in_valid && !o_in_stall) begin
                predict_byte(in_data);
                bytes_taken++;
            end
            // a stalled transaction holds its payload
            if (!in_valid || !o_in_stall) begin
                if (bytes_to_send.size() != 0 &&
                    (steady || $urandom_range(99) >= IDLE_PCT)) begin
                    in_valid <= 1'b1;
                    in_data  <= bytes_to_send.pop_front();
                end else begin
                    // idle cycle, payload is noise
                    in_valid <= 1'b0;
                    in_data  <= t_rgs_in'($urandom);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // output monitor and receiver stall
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_rgs_out want;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                if (runs_due.size() == 0) begin
                    unexpected++;
                    if (mismatches + unexpected <= 10)
                        $display({"%0t: run transaction with none expected: ",
                                  "len %0d sym %h start %0d ovf %b last %b"},
                                 $time, o_out_data.run_length, o_out_data.run_symbol,
                                 o_out_data.run_start, o_out_data.overflow,
                                 o_out_data.last_run);
                end else begin
                    want = runs_due.pop_front();
                    runs_checked++;
                    if (want.overflow) overflow_runs++;
                    if (o_out_data.run_length !== want.run_length ||
                        o_out_data.run_symbol !== want.run_symbol ||
                        o_out_data.run_start  !== want.run_start  ||
                        o_out_data.overflow   !== want.overflow   ||
                        o_out_data.last_run   !== want.last_run) begin
                        mismatches++;
                        if (mismatches + unexpected <= 10) begin
                            $display({"%0t: run mismatch, expected ",
                                      "len %0d sym %h start %0d ovf %b last %b"},
                                     $time, want.run_length, want.run_symbol,
                                     want.run_start, want.overflow, want.last_run);
                            $display({"%0t:               got      ",
                                      "len %0d sym %h start %0d ovf %b last %b"},
                                     $time, o_out_data.run_length, o_out_data.run_symbol,
                                     o_out_data.run_start, o_out_data.overflow,
                                     o_out_data.last_run);
                        end
                    end
                end
            end
            // one long hold-off once armed, random stalls otherwise
            if (hold_go && hold_count < HOLD_CYCLES) begin
                out_stall  <= 1'b1;
                hold_count <= hold_count + 1;
            end else begin
                out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic queue_byte(input logic [SYM_W-1:0] sym, input logic eos);
        t_rgs_in b;
        b.symbol_in     = sym;
        b.end_of_string = eos;
        bytes_to_send.push_back(b);
        bytes_queued++;
        if (eos) strings_queued++;
    endtask

    // queue a run of cnt equal bytes, end mark on its last byte if asked
    task automatic queue_run(input logic [SYM_W-1:0] sym, input int cnt, input logic eos);
        for (int i = 0; i < cnt; i++)
            queue_byte(sym, eos && (i == cnt - 1));
    endtask

    // sender pause: every byte taken and every expected run seen
    task automatic wait_drained();
        while (bytes_taken != bytes_queued || runs_due.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        int random_bytes;
        int nruns;
        int rlen;
        logic [SYM_W-1:0] sym;
        logic [SYM_W-1:0] prev_sym;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: single byte string, symbol extremes
        queue_byte(8'h00, 1'b1);
        queue_run(8'hFF, 3, 1'b0);
        queue_byte(8'h00, 1'b1);
        // equal lengths ordered by earlier start
        queue_run(8'h11, 2, 1'b0);
        queue_run(8'h22, 2, 1'b0);
        queue_byte(8'h33, 1'b0);
        queue_run(8'h44, 2, 1'b1);
        // growing lengths, each insert moves ahead of all held runs
        queue_byte(8'h01, 1'b0);
        queue_run(8'h02, 2, 1'b0);
        queue_run(8'h03, 3, 1'b1);
        // end mark extends the open run, end mark opens a new run
        queue_run(8'hA5, 2, 1'b1);
        queue_run(8'h5A, 2, 1'b0);
        queue_byte(8'hC3, 1'b1);
        wait_drained();

        // table full: more runs than the table holds, no idling on either side
        steady = 1'b1;
        prev_sym = 8'h00;
        for (int r = 0; r < MAX_RUNS + 6; r++) begin
            sym = prev_sym ^ 8'h80 ^ 8'($urandom_range(1, 127));
            rlen = ($urandom_range(9) == 0) ? 2 : 1;
            queue_run(sym, rlen, r == MAX_RUNS + 5);
            prev_sym = sym;
        end
        wait_drained();
        steady = 1'b0;

        // random strings; the receiver holds off for a long stretch at the start
        hold_go = 1'b1;
        random_bytes = 0;
        while (random_bytes < RANDOM_BYTES) begin
            nruns = $urandom_range(1, 8);
            prev_sym = 8'($urandom);
            for (int r = 0; r < nruns; r++) begin
                if ($urandom_range(99) < 30)
                    sym = 8'($urandom_range(0, 3));   // narrow alphabet, neighbors may merge
                else
                    sym = prev_sym + 8'($urandom_range(1, 255));
                rlen = ($urandom_range(9) == 0) ? $urandom_range(6, 20) : $urandom_range(1, 5);
                queue_run(sym, rlen, r == nruns - 1);
                random_bytes += rlen;
                prev_sym = sym;
            end
        end
        wait_drained();

        // allowance for anything the block still sends
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("covered %0d bytes in %0d strings: directed cases, a full run table,",
                 bytes_taken, strings_queued);
        $display("random strings; %0d run transactions checked, %0d flagged overflow",
                 runs_checked, overflow_runs);
        if (mismatches == 0 && unexpected == 0 && runs_due.size() == 0) begin
            $display("tb_run_grouping_sort_by_length_unit passed");
        end else begin
            $display("mismatches %0d, unexpected %0d, still expected %0d",
                     mismatches, unexpected, runs_due.size());
            $display("tb_run_grouping_sort_by_length_unit failed");
        end
        $finish;
    end

    // run limit, well beyond the slowest correct run
    initial begin
        #1_000_000;
        $display("timeout: %0d of %0d bytes taken, %0d runs still expected",
                 bytes_taken, bytes_queued, runs_due.size());
        $display("tb_run_grouping_sort_by_length_unit failed");
        $finish;
    end

endmodule
